// ===== design/ray_box_nearest_hit_core_defines.svh =====
// Assertion macros for the ray/box nearest-hit core checker.
// Included by the checker file only; no dependencies.
`ifndef RAY_BOX_NEAREST_HIT_CORE_DEFINES_SVH
`define RAY_BOX_NEAREST_HIT_CORE_DEFINES_SVH
`define RBN_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RBN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/rbn_pkg.sv =====
// Shared types and constants for the ray/box nearest-hit core.
// No dependencies.
package rbn_pkg;
    localparam int unsigned MaxBoxesDefault = 1024;
    localparam int unsigned FracBitsDefault = 16;
    localparam int unsigned DivSteps = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SLAB,
        ST_FINISH,
        ST_OUT
    } rbn_state_t;

    typedef struct packed {
        logic       load;
        logic       len_step;
        logic       div_start;
        logic       slab_update;
        logic       finish;
        logic       report;
        logic [1:0] axis;
        logic       side;
    } rbn_cmd_t;

    typedef struct packed {
        logic skip;
        logic zero_dir;
        logic zero_miss;
        logic div_done;
        logic last;
        logic len_done;
    } rbn_status_t;
endpackage

// ===== design/rbn_divider.sv =====
// Radix-2 restoring divider for signed 64-bit quotients, truncating toward zero.
// Depends on rbn_pkg.
module rbn_divider
    import rbn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic               done,
    output logic signed [63:0] quot
);
    logic [63:0] n_reg, n_next;
    logic [63:0] d_reg, d_next;
    logic [63:0] q_reg, q_next;
    logic [64:0] r_reg, r_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    assign shifted = {r_reg[63:0], n_reg[63]};
    assign diff    = shifted - {1'b0, d_reg};

    always_comb
    begin
        n_next    = n_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = num[63] ? 64'(-num) : num;
            d_next    = den[63] ? 64'(-den) : den;
            neg_next  = num[63] ^ den[63];
            r_next    = '0;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[62:0], 1'b0};
            if (!diff[64])
            begin
                r_next = diff;
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(DivSteps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? 64'(-q_reg) : q_reg;
endmodule

// ===== design/rbn_datapath.sv =====
// Datapath: item registers, length check, slab interval, nearest-hit tracking.
// Depends on rbn_pkg and rbn_divider.
module rbn_datapath
    import rbn_pkg::*;
#(
    parameter int unsigned MAX_BOXES = MaxBoxesDefault,
    parameter int unsigned FRAC_BITS = FracBitsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rbn_cmd_t           cmd,
    output rbn_status_t        status,
    input  logic [30:0]        min_len_sq,
    input  logic signed [31:0] in_origin [3],
    input  logic signed [31:0] in_dir [3],
    input  logic [30:0]        in_size [3],
    input  logic               in_entry_valid,
    input  logic [9:0]         in_box_index,
    input  logic               in_last,
    output logic               out_hit,
    output logic [9:0]         out_index,
    output logic [30:0]        out_distance
);
    logic signed [31:0] o_reg [3];
    logic signed [31:0] d_reg [3];
    logic [30:0]        s_reg [3];
    logic               ev_reg;
    logic [9:0]         idx_reg;
    logic               last_reg;
    logic [65:0]        len_reg, len_next;
    logic signed [63:0] lo_reg, lo_next;
    logic signed [63:0] hi_reg, hi_next;
    logic signed [63:0] t1_reg;
    logic               miss_reg, miss_next;
    logic [31:0]        best_dist_reg, best_dist_next;
    logic [9:0]         best_idx_reg, best_idx_next;
    logic               any_reg, any_next;
    logic               oh_reg;
    logic [9:0]         oi_reg;
    logic [30:0]        od_reg;

    logic signed [31:0] cur_o, cur_d;
    logic [30:0]        cur_s;
    logic signed [63:0] sq;
    logic signed [34:0] n_lo, n_hi;
    logic signed [63:0] div_num, div_den, quot;
    logic               div_done;
    logic signed [63:0] tmin, tmax, t_sel;
    logic [30:0]        hit_dist;
    logic               in_range;

    assign cur_o = o_reg[cmd.axis];
    assign cur_d = d_reg[cmd.axis];
    assign cur_s = s_reg[cmd.axis];
    assign sq    = cur_d * cur_d;
    assign n_lo  = -$signed({4'b0, cur_s}) - ($signed({{3{cur_o[31]}}, cur_o}) <<< 1);
    assign n_hi  = $signed({4'b0, cur_s}) - ($signed({{3{cur_o[31]}}, cur_o}) <<< 1);
    assign div_num = (cmd.side ? 64'(n_hi) : 64'(n_lo)) <<< FRAC_BITS;
    assign div_den = 64'(cur_d) <<< 1;
    assign in_range = (MAX_BOXES >= 1024) || (32'(idx_reg) < MAX_BOXES);

    rbn_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    assign tmin     = (t1_reg < quot) ? t1_reg : quot;
    assign tmax     = (t1_reg < quot) ? quot : t1_reg;
    assign t_sel    = (lo_reg >= 0) ? lo_reg : hi_reg;
    assign hit_dist = (t_sel > 64'sh7FFFFFFF) ? 31'h7FFFFFFF : t_sel[30:0];

    always_comb
    begin
        len_next       = len_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        miss_next      = miss_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        any_next       = any_reg;
        if (cmd.load)
        begin
            len_next  = '0;
            lo_next   = 64'sh8000000000000000;
            hi_next   = 64'sh7FFFFFFFFFFFFFFF;
            miss_next = 1'b0;
        end
        if (cmd.len_step)
            len_next = len_reg + 66'(unsigned'(sq));
        if (cmd.slab_update)
        begin
            if (cur_d == 0)
                miss_next = miss_reg | !(n_lo <= 0 && n_hi >= 0);
            else
            begin
                if (tmin > lo_reg) lo_next = tmin;
                if (tmax < hi_reg) hi_next = tmax;
            end
        end
        if (cmd.finish && !miss_reg && lo_reg <= hi_reg && hi_reg >= 0
            && {1'b0, hit_dist} < best_dist_reg)
        begin
            best_dist_next = {1'b0, hit_dist};
            best_idx_next  = idx_reg;
            any_next       = 1'b1;
        end
        if (cmd.report)
        begin
            best_dist_next = 32'hFFFFFFFF;
            best_idx_next  = '0;
            any_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg <= 32'hFFFFFFFF;
            best_idx_reg  <= '0;
            any_reg       <= 1'b0;
        end
        else
        begin
            best_dist_reg <= best_dist_next;
            best_idx_reg  <= best_idx_next;
            any_reg       <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            o_reg    <= in_origin;
            d_reg    <= in_dir;
            s_reg    <= in_size;
            ev_reg   <= in_entry_valid;
            idx_reg  <= in_box_index;
            last_reg <= in_last;
        end
        if (div_done && !cmd.side)
            t1_reg <= quot;
        if (cmd.report)
        begin
            oh_reg <= any_reg;
            oi_reg <= any_reg ? best_idx_reg : 10'd0;
            od_reg <= any_reg ? best_dist_reg[30:0] : 31'd0;
        end
        len_reg  <= len_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        miss_reg <= miss_next;
    end

    assign status.skip      = !ev_reg || !in_range
                              || ((len_reg >> FRAC_BITS) < {35'b0, min_len_sq});
    assign status.zero_dir  = (cur_d == 0);
    assign status.zero_miss = miss_reg;
    assign status.div_done  = div_done;
    assign status.last      = last_reg;
    assign status.len_done  = (cmd.axis == 2'd2);

    assign out_hit      = oh_reg;
    assign out_index    = oi_reg;
    assign out_distance = od_reg;
endmodule

// ===== design/rbn_controller.sv =====
// Controller state machine sequencing the length sum, up to six divisions and report.
// Depends on rbn_pkg.
module rbn_controller
    import rbn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  logic        out_free,
    input  rbn_status_t status,
    output rbn_cmd_t    cmd,
    output logic        in_ready,
    output logic        out_load
);
    rbn_state_t  state_reg, state_next;
    logic [1:0]  axis_reg, axis_next;
    logic        side_reg, side_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        side_next  = side_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    state_next = ST_LEN;
                    axis_next  = 2'd0;
                end
            ST_LEN:
                if (axis_reg == 2'd2)
                    state_next = ST_CHECK;
                else
                    axis_next = axis_reg + 2'd1;
            ST_CHECK:
            begin
                axis_next = 2'd0;
                side_next = 1'b0;
                state_next = status.skip ? ST_FINISH : ST_DIV_START;
            end
            ST_DIV_START:
                state_next = status.zero_dir ? ST_SLAB : ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (status.div_done)
                begin
                    if (!side_reg)
                    begin
                        side_next  = 1'b1;
                        state_next = ST_DIV_START;
                    end
                    else
                        state_next = ST_SLAB;
                end
            ST_SLAB:
            begin
                side_next = 1'b0;
                if (axis_reg == 2'd2)
                    state_next = ST_FINISH;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_DIV_START;
                end
            end
            ST_FINISH:
                state_next = status.last ? ST_OUT : ST_IDLE;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.axis = axis_reg;
        cmd.side = side_reg;
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            ST_LEN:       cmd.len_step = 1'b1;
            ST_DIV_START: cmd.div_start = !status.zero_dir;
            ST_SLAB:      cmd.slab_update = 1'b1;
            ST_FINISH:    cmd.finish = !status.skip;
            ST_OUT:
            begin
                cmd.report = out_free;
                out_load   = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            side_reg  <= side_next;
        end
    end
endmodule

// ===== design/ray_box_nearest_hit_core.sv =====
// Ray/box nearest-hit picking core: top level.
// Depends on rbn_pkg, rbn_controller, rbn_datapath, rbn_divider.
// A skipped box passes the length sum, the check and the finish state only; a box
// that ends a pick also passes the output state. A tested box adds, per axis with
// nonzero direction, two divisions on a single radix-2 divider of 64 steps, then a
// slab update, and for a zero axis a slab update alone. One item is in work at a
// time; the result register holds the pick result until taken while the next item
// is accepted, and only the report of a later pick waits on it.
module ray_box_nearest_hit_core
    import rbn_pkg::*;
#(
    parameter int unsigned MAX_BOXES = MaxBoxesDefault,
    parameter int unsigned FRAC_BITS = FracBitsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic [30:0]        size_x,
    input  logic [30:0]        size_y,
    input  logic [30:0]        size_z,
    input  logic               entry_valid,
    input  logic [9:0]         box_index,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic [9:0]         nearest_index,
    output logic [30:0]        nearest_distance
);
    logic [30:0]        min_len_reg;
    logic               ov_reg, ov_next;
    logic               out_load;
    logic               in_fire;
    rbn_cmd_t           cmd;
    rbn_status_t        status;
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic [30:0]        siz [3];

    assign org = '{origin_x, origin_y, origin_z};
    assign dir = '{dir_x, dir_y, dir_z};
    assign siz = '{size_x, size_y, size_z};
    assign in_fire = in_valid && in_ready;

    rbn_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (!ov_reg || out_ready),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_ready),
        .out_load (out_load)
    );

    rbn_datapath #(
        .MAX_BOXES (MAX_BOXES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .min_len_sq     (min_len_reg),
        .in_origin      (org),
        .in_dir         (dir),
        .in_size        (siz),
        .in_entry_valid (entry_valid),
        .in_box_index   (box_index),
        .in_last        (last),
        .out_hit        (hit),
        .out_index      (nearest_index),
        .out_distance   (nearest_distance)
    );

    always_comb
    begin
        ov_next = ov_reg;
        if (out_ready)
            ov_next = 1'b0;
        if (out_load)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                min_len_reg <= cfg_wdata;
            ov_reg <= ov_next;
        end
    end

    assign out_valid = ov_reg;
endmodule

// ===== design/rbn_checker.sv =====
// Port-level checker for the ray/box nearest-hit core, bound to the top level.
// Depends on ray_box_nearest_hit_core_defines.svh.
`include "ray_box_nearest_hit_core_defines.svh"
module rbn_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        hit,
    input logic [9:0]  nearest_index,
    input logic [30:0] nearest_distance
);
    `RBN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(nearest_distance))
    `RBN_ASSERT_IMPL(a_miss_zero, out_valid && !hit, nearest_index == 10'd0)
    `RBN_ASSERT_IMPL(a_miss_dist, out_valid && !hit, nearest_distance == 31'd0)
    `RBN_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
endmodule

bind ray_box_nearest_hit_core rbn_checker u_rbn_checker (.*);
